// ===== rtl/core/shbs_pkg.sv =====
`default_nettype none

package shbs_pkg;

    localparam logic REQ_ABSORB   = 1'b0;
    localparam logic REQ_FINALIZE = 1'b1;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [5:0] LAST_BYTE  = 6'd63;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [2:0] LAST_WORD  = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_FOLD,
        ST_OUT
    } shbs_state_t;

    typedef struct packed {
        logic byte_en;
        logic word_en;
    } shbs_sched_ctl_t;

    typedef struct packed {
        logic       load;
        logic       run;
        logic       fold;
        logic       emit;
        logic [5:0] rnd;
        logic [2:0] iv_sel;
    } shbs_round_ctl_t;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/shbs_sched.sv =====
`default_nettype none

module shbs_sched (
    input  wire                        aclk,
    input  wire shbs_pkg::shbs_sched_ctl_t ctl,
    input  wire [7:0]                  byte_in,
    output logic [31:0]                w_out
);
    import shbs_pkg::*;

    // Block buffer doubles as the 16-word schedule window; oldest word at the top.
    logic [511:0] blk_reg;
    logic [511:0] blk_next;
    logic [31:0]  w0, w1, w9, w14, w_new;

    assign w0  = blk_reg[511:480];
    assign w1  = blk_reg[479:448];
    assign w9  = blk_reg[223:192];
    assign w14 = blk_reg[63:32];
    assign w_new = small_sigma1(w14) + w9 + small_sigma0(w1) + w0;
    assign w_out = w0;

    always_comb begin
        blk_next = blk_reg;
        if (ctl.byte_en) begin
            blk_next = {blk_reg[503:0], byte_in};
        end else if (ctl.word_en) begin
            blk_next = {blk_reg[479:0], w_new};
        end
    end

    always_ff @(posedge aclk) begin
        blk_reg <= blk_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/shbs_round.sv =====
`default_nettype none

module shbs_round (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire shbs_pkg::shbs_round_ctl_t ctl,
    input  wire [31:0]                  w_in,
    output logic [31:0]                 head_word
);
    import shbs_pkg::*;

    logic [31:0] h_reg [8];
    logic [31:0] h_next [8];
    logic [31:0] v_reg [8];
    logic [31:0] v_next [8];
    logic [31:0] t1, t2, ch, maj;

    assign ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1  = v_reg[7] + big_sigma1(v_reg[4]) + ch + ROUND_K[ctl.rnd] + w_in;
    assign t2  = big_sigma0(v_reg[0]) + maj;
    assign head_word = h_reg[0];

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            v_next[i] = v_reg[i];
            h_next[i] = h_reg[i];
        end
        if (ctl.load) begin
            for (int i = 0; i < 8; i++) begin
                v_next[i] = h_reg[i];
            end
        end else if (ctl.run) begin
            v_next[7] = v_reg[6];
            v_next[6] = v_reg[5];
            v_next[5] = v_reg[4];
            v_next[4] = v_reg[3] + t1;
            v_next[3] = v_reg[2];
            v_next[2] = v_reg[1];
            v_next[1] = v_reg[0];
            v_next[0] = t1 + t2;
        end
        if (ctl.fold) begin
            for (int i = 0; i < 8; i++) begin
                h_next[i] = h_reg[i] + v_reg[i];
            end
        end else if (ctl.emit) begin
            // after eight shifts the chain holds the initial values again
            for (int i = 0; i < 7; i++) begin
                h_next[i] = h_reg[i + 1];
            end
            h_next[7] = INIT_H[ctl.iv_sel];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) begin
                h_reg[i] <= INIT_H[i];
            end
        end else begin
            for (int i = 0; i < 8; i++) begin
                h_reg[i] <= h_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 8; i++) begin
            v_reg[i] <= v_next[i];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sha256_byte_stream_hasher.sv =====
`default_nettype none

// Channel   Dir  Handshake          Payload
// s_        in   s_valid / s_ready  s_req_type, s_data_byte
// m_        out  m_valid / m_ready  m_digest_word, m_word_index, m_last_word
//
// Absorb request: the 64th byte of a block starts a compression (64 rounds, 1 fold), with s_ready low.
// Finalize: once accepted, one pad byte per cycle up to each block end and a compression
// per padded block (one or two), then 8 digest words at one per cycle while m_ready is high.
// Reset is synchronous; s_ready is low from a finalize until the last word is taken.

module sha256_byte_stream_hasher (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire         s_req_type,
    input  wire [7:0]   s_data_byte,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word
);
    import shbs_pkg::*;

    shbs_state_t     state_reg, state_next;
    logic [5:0]      fill_reg, fill_next;
    logic [60:0]     len_reg, len_next;
    logic [5:0]      rnd_reg, rnd_next;
    logic [2:0]      idx_reg, idx_next;
    logic            mark_reg, mark_next;   // 0x80 still to be placed
    logic            fin_reg, fin_next;     // current block carries the length
    logic            final_reg, final_next; // finalize in progress
    logic [63:0]     len_bits;
    logic [7:0]      pad_byte;
    logic [7:0]      byte_sel;
    logic [31:0]     w_word;
    shbs_sched_ctl_t sched_ctl;
    shbs_round_ctl_t round_ctl;

    assign len_bits = {len_reg, 3'b000};

    always_comb begin
        if (mark_reg) begin
            pad_byte = PAD_BYTE;
        end else if (fin_reg && fill_reg >= LEN_POS) begin
            pad_byte = len_bits[{~fill_reg[2:0], 3'b000} +: 8];
        end else begin
            pad_byte = 8'h00;
        end
    end

    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        len_next   = len_reg;
        rnd_next   = rnd_reg;
        idx_next   = idx_reg;
        mark_next  = mark_reg;
        fin_next   = fin_reg;
        final_next = final_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        byte_sel   = s_data_byte;
        sched_ctl  = '0;
        round_ctl  = '0;
        round_ctl.rnd    = rnd_reg;
        round_ctl.iv_sel = idx_reg;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_req_type == REQ_ABSORB) begin
                        sched_ctl.byte_en = 1'b1;
                        fill_next = fill_reg + 6'd1;
                        len_next  = len_reg + 61'd1;
                        if (fill_reg == LAST_BYTE) begin
                            round_ctl.load = 1'b1;
                            rnd_next   = '0;
                            state_next = ST_COMP;
                        end
                    end else begin
                        final_next = 1'b1;
                        mark_next  = 1'b1;
                        fin_next   = 1'b0;
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                byte_sel = pad_byte;
                sched_ctl.byte_en = 1'b1;
                fill_next = fill_reg + 6'd1;
                if (mark_reg) begin
                    mark_next = 1'b0;
                    fin_next  = (fill_reg < LEN_POS);
                end
                if (fill_reg == LAST_BYTE) begin
                    round_ctl.load = 1'b1;
                    rnd_next   = '0;
                    state_next = ST_COMP;
                end
            end
            ST_COMP: begin
                round_ctl.run     = 1'b1;
                sched_ctl.word_en = 1'b1;
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == LAST_ROUND) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                round_ctl.fold = 1'b1;
                if (!final_reg) begin
                    state_next = ST_IDLE;
                end else if (fin_reg) begin
                    len_next   = '0;
                    idx_next   = '0;
                    final_next = 1'b0;
                    state_next = ST_OUT;
                end else begin
                    // extra block: zeros, then the length
                    fin_next   = 1'b1;
                    state_next = ST_PAD;
                end
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    round_ctl.emit = 1'b1;
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == LAST_WORD) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            len_reg   <= '0;
            rnd_reg   <= '0;
            idx_reg   <= '0;
            mark_reg  <= 1'b0;
            fin_reg   <= 1'b0;
            final_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            len_reg   <= len_next;
            rnd_reg   <= rnd_next;
            idx_reg   <= idx_next;
            mark_reg  <= mark_next;
            fin_reg   <= fin_next;
            final_reg <= final_next;
        end
    end

    assign m_word_index = idx_reg;
    assign m_last_word  = (idx_reg == LAST_WORD);

    shbs_sched u_sched (
        .aclk    (aclk),
        .ctl     (sched_ctl),
        .byte_in (byte_sel),
        .w_out   (w_word)
    );

    shbs_round u_round (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (round_ctl),
        .w_in      (w_word),
        .head_word (m_digest_word)
    );

endmodule

`default_nettype wire

// ===== rtl/core/shbs_checker.sv =====
`default_nettype none

module shbs_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_ready,
    input wire        m_valid,
    input wire        m_ready,
    input wire [31:0] m_digest_word,
    input wire [2:0]  m_word_index,
    input wire        m_last_word
);

    // no new request while a digest is going out
    a_no_accept_during_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("s_ready high while digest words are pending");

    a_first_index: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> (m_word_index == 3'd0))
        else $error("digest does not start at word 0");

    a_index_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_word) |=>
            (m_valid && m_word_index == 3'($past(m_word_index) + 3'd1)))
        else $error("digest word index did not advance by one");

    a_end_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_word) |=> !m_valid)
        else $error("valid stayed high after the last digest word");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_digest_word) && $stable(m_word_index)))
        else $error("stalled digest word changed");

endmodule

bind sha256_byte_stream_hasher shbs_checker u_shbs_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_digest_word (m_digest_word),
    .m_word_index  (m_word_index),
    .m_last_word   (m_last_word)
);

`default_nettype wire
